### design/binomial_european_option_pricer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binomial pricer
// Implication checks clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_EUROPEAN_OPTION_PRICER_DEFINES_SVH
`define BINOMIAL_EUROPEAN_OPTION_PRICER_DEFINES_SVH

// Same-cycle implication.
`define BEP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bep assertion failed");

// Next-cycle implication.
`define BEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bep assertion failed");

`endif

### design/bep_pkg.sv
// ----------------------------------------------------------------------------
// bep_pkg
// Types, codes and fixed-point helpers shared by the binomial pricer.
// ----------------------------------------------------------------------------
package bep_pkg;

  localparam int unsigned MAX_STEPS_DEF = 256;
  localparam int unsigned DVW           = 60;
  localparam logic [31:0] ONE_Q28       = 32'h1000_0000;

  typedef struct packed {
    logic        option_kind;
    logic [31:0] spot;
    logic [31:0] strike;
    logic [31:0] up_factor;
    logic [31:0] gross_rate;
    logic [8:0]  step_count;
  } in_req_t;

  typedef struct packed {
    logic [31:0] price;
    logic        status;
  } out_res_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_DIV_D, OP_DIV_P, OP_DIV_R, OP_CHAIN_U, OP_CHAIN_D, OP_INDUCT, OP_ROOT
  } dp_op_t;

  typedef struct packed {
    logic   go;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic u_bad;
    logic r_bad;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_D, ST_DIV_P, ST_DIV_R, ST_CHAIN_U, ST_CHAIN_D,
    ST_INDUCT, ST_ROOT, ST_REPORT, ST_FAULT
  } ctrl_state_t;

  // Round a Q28-scaled product to integer and saturate to 32 bits.
  function automatic logic [31:0] rnd_sat(input logic [65:0] x);
    logic [65:0] s;
    s = x + 66'h800_0000;
    if (|s[65:60]) return 32'hFFFF_FFFF;
    return s[59:28];
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] price,
                                         input logic [31:0] strike,
                                         input logic        is_put);
    if (is_put) return (strike > price) ? strike - price : 32'd0;
    return (price > strike) ? price - strike : 32'd0;
  endfunction

endpackage

### design/binomial_european_option_pricer.sv
// The node pass (one update per cycle within a row, plus a pipeline drain per
// row) and the serial divider dominate the run time. An invalid u, or an R out
// of range, ends the run early with an error result. One request at a time;
// busy is high until the result strobe. Synchronous active-low reset idles the
// block.
// ----------------------------------------------------------------------------
// binomial_european_option_pricer
// Binomial-lattice European call/put pricer, Q16.16 prices, Q4.28 factors.
// ----------------------------------------------------------------------------
`include "binomial_european_option_pricer_defines.svh"

module binomial_european_option_pricer #(
  parameter int unsigned MAX_STEPS = bep_pkg::MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bep_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output bep_pkg::out_res_t out_res
);
  import bep_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] root;
  logic        err;

  bep_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_err    (err)
  );

  bep_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .cmd    (cmd),
    .stat   (stat),
    .root   (root)
  );

  assign out_res.price  = err ? 32'd0 : root;
  assign out_res.status = err;

  `BEP_ASSERT_NOW(a_strobe_busy, out_strobe, busy)
  `BEP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `BEP_ASSERT_NEXT(a_strobe_once, out_strobe, !out_strobe && !busy)
  `BEP_ASSERT_NOW(a_err_zero, out_strobe && out_res.status, out_res.price == 32'd0)

endmodule

### design/bep_div.sv
// ----------------------------------------------------------------------------
// bep_div
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module bep_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [bep_pkg::DVW-1:0] dividend,
  input  logic [31:0]             divisor,
  output logic                    done,
  output logic [31:0]             quotient
);
  import bep_pkg::*;

  localparam int unsigned CW = $clog2(DVW + 1);

  logic [DVW-1:0] quo_r;
  logic [31:0]    rem_r, dvs_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [32:0]    sh;
  logic           qbit;

  assign sh   = {rem_r, quo_r[DVW-1]};
  assign qbit = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVW-2:0], qbit};
      rem_r <= qbit ? 32'(sh - {1'b0, dvs_r}) : sh[31:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[31:0];

endmodule

### design/bep_dp.sv
// ----------------------------------------------------------------------------
// bep_dp
// Pricer datapath: factor divisions, leaf chains, lattice column memory and
// the pipelined backward-induction node update.
// ----------------------------------------------------------------------------
module bep_dp #(
  parameter int unsigned MAX_STEPS = bep_pkg::MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bep_pkg::in_req_t  in_req,
  input  bep_pkg::dp_cmd_t  cmd,
  output bep_pkg::dp_stat_t stat,
  output logic [31:0]       root
);
  import bep_pkg::*;

  localparam int unsigned NW    = $clog2(MAX_STEPS + 1);
  localparam int unsigned DEPTH = MAX_STEPS + 1;

  // request fields
  logic          kind_r;
  logic [31:0]   spot_r, strike_r, u_r, r_r;
  logic [NW-1:0] n_r;
  logic [31:0]   d_r, p_r, q_r, disc_r;

  logic [31:0] mem [DEPTH];

  dp_op_t op_r;
  logic   run_r, done_r, rt1_r;

  // divider
  logic              div_go, div_done;
  logic [DVW-1:0]    div_dvd;
  logic [31:0]       div_dvs, div_q;

  // leaf chain
  logic [NW-1:0] c_r;
  logic [31:0]   v_r;
  logic [63:0]   cm_r;
  logic          sub_r;
  logic          is_chain, up;
  logic [31:0]   fac;
  logic [NW:0]   sum_nc, dif_nc;
  logic [NW-1:0] leaf_idx;
  logic          leaf_wr, chain_end;

  // induction
  logic          ind, ind_end, issue_r, pipe_busy;
  logic [NW-1:0] row_r, k_r, raddr;
  logic          v1_r, v2_r, v3_r, v4_r;
  logic [NW-1:0] k1_r, a2_r, a3_r, a4_r;
  logic [31:0]   rdata_r, prev_r, t_r;
  logic [63:0]   mu_r, md_r, m3_r;

  assign stat.u_bad = (u_r <= ONE_Q28);
  assign stat.r_bad = (r_r <= d_r) || (r_r >= u_r);
  assign stat.done  = done_r;
  assign root       = rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.go && cmd.op == OP_LOAD) begin
      kind_r   <= in_req.option_kind;
      spot_r   <= in_req.spot;
      strike_r <= in_req.strike;
      u_r      <= in_req.up_factor;
      r_r      <= in_req.gross_rate;
      if (32'(in_req.step_count) > 32'(MAX_STEPS)) n_r <= NW'(MAX_STEPS);
      else n_r <= NW'(in_req.step_count);
    end
  end

  // ---- divisions ----
  assign div_go = cmd.go && (cmd.op == OP_DIV_D || cmd.op == OP_DIV_P || cmd.op == OP_DIV_R);

  always_comb begin
    div_dvd = DVW'(1) << 56;
    div_dvs = u_r;
    case (cmd.op)
      OP_DIV_P: begin
        div_dvd = DVW'(r_r - d_r) << 28;
        div_dvs = u_r - d_r;
      end
      OP_DIV_R: div_dvs = r_r;
      default:  ;
    endcase
  end

  bep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (op_r)
        OP_DIV_D: d_r <= div_q;
        OP_DIV_P: begin
          p_r <= div_q;
          q_r <= ONE_Q28 - div_q;
        end
        OP_DIV_R: disc_r <= div_q;
        default:  ;
      endcase
    end
  end

  // ---- leaf chains: iterate S0*f, write a leaf on matching parity ----
  assign is_chain  = run_r && (op_r == OP_CHAIN_U || op_r == OP_CHAIN_D);
  assign up        = (op_r == OP_CHAIN_U);
  assign fac       = up ? u_r : d_r;
  assign sum_nc    = {1'b0, n_r} + {1'b0, c_r};
  assign dif_nc    = {1'b0, n_r} - {1'b0, c_r};
  assign leaf_idx  = up ? sum_nc[NW:1] : dif_nc[NW:1];
  assign leaf_wr   = is_chain && !sub_r && (c_r[0] == n_r[0]) && (up || c_r != '0);
  assign chain_end = is_chain && !sub_r && (c_r == n_r);

  always_ff @(posedge clk) begin
    if (cmd.go && (cmd.op == OP_CHAIN_U || cmd.op == OP_CHAIN_D)) begin
      c_r <= '0;
      v_r <= spot_r;
    end else if (is_chain) begin
      if (!sub_r) begin
        cm_r <= {32'd0, v_r} * {32'd0, fac};
      end else begin
        v_r <= rnd_sat({2'b00, cm_r});
        c_r <= c_r + 1'b1;
      end
    end
  end

  // ---- induction: issue one read per node, four-stage update pipe ----
  assign ind       = run_r && (op_r == OP_INDUCT);
  assign pipe_busy = v1_r | v2_r | v3_r | v4_r;
  assign ind_end   = ind && !issue_r && !pipe_busy && (row_r <= NW'(1));
  assign raddr     = (ind && issue_r) ? k_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_LOAD;
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      rt1_r   <= 1'b0;
      sub_r   <= 1'b0;
      issue_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      done_r <= div_done | chain_end | ind_end | rt1_r;
      rt1_r  <= cmd.go && (cmd.op == OP_ROOT);
      v1_r   <= ind && issue_r;
      v2_r   <= v1_r && (k1_r != '0);
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      if (cmd.go) begin
        op_r  <= cmd.op;
        run_r <= (cmd.op == OP_CHAIN_U || cmd.op == OP_CHAIN_D || cmd.op == OP_INDUCT);
        sub_r <= 1'b0;
        if (cmd.op == OP_INDUCT) issue_r <= (n_r != '0);
      end else begin
        if (chain_end || ind_end) run_r <= 1'b0;
        if (is_chain && !chain_end) sub_r <= !sub_r;
        if (ind && issue_r && k_r == row_r) issue_r <= 1'b0;
        else if (ind && !issue_r && !pipe_busy && row_r > NW'(1)) issue_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && cmd.op == OP_INDUCT) begin
      row_r <= n_r;
      k_r   <= '0;
    end else if (ind) begin
      if (issue_r) begin
        if (k_r != row_r) k_r <= k_r + 1'b1;
      end else if (!pipe_busy && row_r > NW'(1)) begin
        row_r <= row_r - 1'b1;
        k_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    k1_r    <= k_r;
    if (v1_r) prev_r <= rdata_r;
    a2_r <= k1_r - 1'b1;
    mu_r <= {32'd0, p_r} * {32'd0, rdata_r};
    md_r <= {32'd0, q_r} * {32'd0, prev_r};
    a3_r <= a2_r;
    t_r  <= rnd_sat({2'b00, mu_r} + {2'b00, md_r});
    a4_r <= a3_r;
    m3_r <= {32'd0, t_r} * {32'd0, disc_r};
  end

  always_ff @(posedge clk) begin
    if (v4_r) mem[a4_r] <= rnd_sat({2'b00, m3_r});
    else if (leaf_wr) mem[leaf_idx] <= payoff(v_r, strike_r, kind_r);
  end

endmodule

### design/bep_ctrl.sv
// ----------------------------------------------------------------------------
// bep_ctrl
// Pricer sequencer: steps the datapath through divisions, leaves,
// induction and the root read, then strobes the result; a bad u or R strobes an error.
// ----------------------------------------------------------------------------
module bep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bep_pkg::dp_stat_t stat,
  output bep_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_strobe,
  output logic              out_err
);
  import bep_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        launched_r, launched_nxt;
  logic        in_phase;
  dp_op_t      ph_op;
  ctrl_state_t ph_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    cmd.go       = 1'b0;
    cmd.op       = OP_LOAD;
    out_strobe   = 1'b0;
    out_err      = 1'b0;
    in_phase     = 1'b0;
    ph_op        = OP_LOAD;
    ph_next      = ST_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        cmd.go = start;
        if (start) begin
          state_nxt    = ST_DIV_D;
          launched_nxt = 1'b0;
        end
      end
      ST_DIV_D: begin
        if (stat.u_bad) state_nxt = ST_FAULT;
        else begin
          in_phase = 1'b1;
          ph_op    = OP_DIV_D;
          ph_next  = ST_DIV_P;
        end
      end
      ST_DIV_P: begin
        if (stat.r_bad) state_nxt = ST_FAULT;
        else begin
          in_phase = 1'b1;
          ph_op    = OP_DIV_P;
          ph_next  = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        in_phase = 1'b1;
        ph_op    = OP_DIV_R;
        ph_next  = ST_CHAIN_U;
      end
      ST_CHAIN_U: begin
        in_phase = 1'b1;
        ph_op    = OP_CHAIN_U;
        ph_next  = ST_CHAIN_D;
      end
      ST_CHAIN_D: begin
        in_phase = 1'b1;
        ph_op    = OP_CHAIN_D;
        ph_next  = ST_INDUCT;
      end
      ST_INDUCT: begin
        in_phase = 1'b1;
        ph_op    = OP_INDUCT;
        ph_next  = ST_ROOT;
      end
      ST_ROOT: begin
        in_phase = 1'b1;
        ph_op    = OP_ROOT;
        ph_next  = ST_REPORT;
      end
      ST_REPORT: begin
        out_strobe = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FAULT: begin
        out_strobe = 1'b1;
        out_err    = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // launch the phase once, advance on its done pulse
    if (in_phase) begin
      cmd.op       = ph_op;
      cmd.go       = !launched_r;
      launched_nxt = 1'b1;
      if (stat.done) begin
        state_nxt    = ph_next;
        launched_nxt = 1'b0;
      end
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
